// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on i_clk, held off during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TTS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define TTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/tts_pkg.sv =====
// ---------------------------------------------------------------------------
// tts_pkg
// Shared types and codes of the tick task scheduler.
// ---------------------------------------------------------------------------
`default_nettype none

package tts_pkg;

    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_ADD  = 1'b1;

    typedef enum logic [1:0] {
        KIND_ADDED = 2'd0,
        KIND_FULL  = 2'd1,
        KIND_DUE   = 2'd2,
        KIND_IDLE  = 2'd3
    } t_kind;

    typedef struct packed {
        logic start;
        logic rd;
        logic step;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic is_add;
        logic full;
        logic empty;
        logic last_slot;
        logic due;
        logic pend_v;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/tts_ctrl.sv =====
// ---------------------------------------------------------------------------
// tts_ctrl
// Sequencer: accepts an item, walks the slot table for a non-empty tick, flushes the last result.
// ---------------------------------------------------------------------------
`default_nettype none

module tts_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire tts_pkg::t_status i_status,
    output tts_pkg::t_cmd         o_cmd
);
    import tts_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_EVAL  = 4'b0100,
        ST_FLUSH = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   can_step;

    assign can_step = !(i_status.due && i_status.pend_v && !i_status.out_free);

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = i_rst_n;
                if (i_s_tvalid && i_rst_n) begin
                    o_cmd.start = 1'b1;
                    if (i_status.is_add || i_status.empty) begin
                        n_state = ST_FLUSH;
                    end else begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_EVAL;
            end
            ST_EVAL: begin
                if (can_step) begin
                    o_cmd.step = 1'b1;
                    n_state    = i_status.last_slot ? ST_FLUSH : ST_READ;
                end
            end
            ST_FLUSH: begin
                if (i_status.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tts_dp.sv =====
// ---------------------------------------------------------------------------
// tts_dp
// Slot table memories, fill count, walk index, pending result, output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module tts_dp #(
    parameter int MAX_TASKS = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire tts_pkg::t_cmd    i_cmd,
    output tts_pkg::t_status      o_status,
    input  wire logic             i_action,
    input  wire logic [7:0]       i_task,
    input  wire logic [31:0]      i_start,
    input  wire logic [31:0]      i_period,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output tts_pkg::t_kind        o_out_kind,
    output logic [2:0]            o_out_slot,
    output logic [7:0]            o_out_task,
    output logic                  o_out_last
);
    import tts_pkg::*;

    localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int FW = $clog2(MAX_TASKS + 1);

    logic [7:0]  mem_task   [MAX_TASKS];
    logic [31:0] mem_delay  [MAX_TASKS];
    logic [31:0] mem_period [MAX_TASKS];

    logic [FW-1:0] r_fill;
    logic [IW-1:0] r_idx;
    logic [7:0]    r_rd_task;
    logic [31:0]   r_rd_delay;
    logic [31:0]   r_rd_period;

    logic          r_pend_v;
    t_kind         r_pend_kind;
    logic [2:0]    r_pend_slot;
    logic [7:0]    r_pend_task;

    logic          r_out_valid;
    t_kind         r_out_kind;
    logic [2:0]    r_out_slot;
    logic [7:0]    r_out_task;
    logic          r_out_last;

    logic          add_wr;
    logic          dly_wr;
    logic [IW-1:0] dly_addr;
    logic [31:0]   dly_data;
    logic          due;
    logic          push_mid;

    assign due       = (r_rd_delay == 32'd0);
    assign add_wr    = i_cmd.start && (i_action == ACT_ADD) && !o_status.full;
    assign dly_wr    = add_wr || i_cmd.step;
    assign dly_addr  = add_wr ? r_fill[IW-1:0] : r_idx;
    assign dly_data  = add_wr ? i_start : (due ? r_rd_period : r_rd_delay - 32'd1);
    assign push_mid  = i_cmd.step && due && r_pend_v;

    assign o_status.is_add    = (i_action == ACT_ADD);
    assign o_status.full      = (r_fill == FW'(MAX_TASKS));
    assign o_status.empty     = (r_fill == '0);
    assign o_status.last_slot = ((FW'(r_idx) + FW'(1)) == r_fill);
    assign o_status.due       = due;
    assign o_status.pend_v    = r_pend_v;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (add_wr) begin
            mem_task[r_fill[IW-1:0]]   <= i_task;
            mem_period[r_fill[IW-1:0]] <= i_period;
        end
        if (dly_wr) begin
            mem_delay[dly_addr] <= dly_data;
        end
        if (i_cmd.rd) begin
            r_rd_task   <= mem_task[r_idx];
            r_rd_delay  <= mem_delay[r_idx];
            r_rd_period <= mem_period[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_idx    <= '0;
            r_pend_v <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_idx <= '0;
                if (i_action == ACT_ADD) begin
                    r_pend_v <= 1'b1;
                    if (add_wr) begin
                        r_fill <= r_fill + FW'(1);
                    end
                end else begin
                    r_pend_v <= 1'b0;
                end
            end
            if (i_cmd.step) begin
                r_idx <= r_idx + IW'(1);
                if (due) begin
                    r_pend_v <= 1'b1;
                end
            end
            if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            if (add_wr) begin
                r_pend_kind <= KIND_ADDED;
                r_pend_slot <= 3'(r_fill);
                r_pend_task <= i_task;
            end else begin
                r_pend_kind <= KIND_FULL;
                r_pend_slot <= 3'd0;
                r_pend_task <= 8'd0;
            end
        end else if (i_cmd.step && due) begin
            r_pend_kind <= KIND_DUE;
            r_pend_slot <= 3'(r_idx);
            r_pend_task <= r_rd_task;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push_mid || i_cmd.flush) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_mid) begin
            r_out_kind <= r_pend_kind;
            r_out_slot <= r_pend_slot;
            r_out_task <= r_pend_task;
            r_out_last <= 1'b0;
        end else if (i_cmd.flush) begin
            r_out_last <= 1'b1;
            if (r_pend_v) begin
                r_out_kind <= r_pend_kind;
                r_out_slot <= r_pend_slot;
                r_out_task <= r_pend_task;
            end else begin
                r_out_kind <= KIND_IDLE;
                r_out_slot <= 3'd0;
                r_out_task <= 8'd0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_out_kind;
    assign o_out_slot  = r_out_slot;
    assign o_out_task  = r_out_task;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/tick_task_scheduler.sv =====
// ---------------------------------------------------------------------------
// tick_task_scheduler
// Time-triggered task table: add items fill slots, tick items report due tasks.
// ---------------------------------------------------------------------------
//   channel  dir  tdata                                        tuser   tlast
//   s        in   task_id, start_delay, reload_period          action  -
//   m        out  slot, due_task                               kind    last
//
// Add: accept, then flush. Tick: accept, then for each filled slot a
// registered table read and an evaluate/write-back, then flush.
// Reset clears the fill count, walk index and valid flags, not the table; the table needs no clearing pass.
// A stalled output holds the walk only when a second due result is ready.
// ---------------------------------------------------------------------------
`default_nettype none

module tick_task_scheduler #(
    parameter int MAX_TASKS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [71:0] i_s_tdata,   // task_id[7:0], start_delay[39:8], reload_period[71:40]
    input  wire logic [0:0]  i_s_tuser,   // action[0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // slot[2:0], due_task[10:3], zero[15:11]
    output logic [1:0]       o_m_tuser,   // kind[1:0]
    output logic             o_m_tlast
);
    import tts_pkg::*;

    `include "assert_macros.svh"

    t_cmd       cmd;
    t_status    status;
    t_kind      out_kind;
    logic [2:0] out_slot;
    logic [7:0] out_task;

    tts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tts_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_action    (i_s_tuser[0]),
        .i_task      (i_s_tdata[7:0]),
        .i_start     (i_s_tdata[39:8]),
        .i_period    (i_s_tdata[71:40]),
        .o_out_valid (o_m_tvalid),
        .i_out_ready (i_m_tready),
        .o_out_kind  (out_kind),
        .o_out_slot  (out_slot),
        .o_out_task  (out_task),
        .o_out_last  (o_m_tlast)
    );

    assign o_m_tdata = {5'd0, out_task, out_slot};
    assign o_m_tuser = out_kind;

    `TTS_ASSERT_NEXT(a_busy_after_accept, i_s_tvalid && o_s_tready, !o_s_tready)
    `TTS_ASSERT_IMPL(a_add_result_last,
        o_m_tvalid && (o_m_tuser == KIND_ADDED || o_m_tuser == KIND_FULL), o_m_tlast)
    `TTS_ASSERT_IMPL(a_idle_result_clean,
        o_m_tvalid && (o_m_tuser == KIND_IDLE), o_m_tlast && (o_m_tdata == 16'd0))

endmodule

`default_nettype wire
